FILE: rtl/core/qsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types, codes and helpers for the quoted string unescaper.
// ----------------------------------------------------------------------------
package qsu_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ERR_W  = 3;

  // parser phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4
  } phase_t;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NO_OPEN  = 3'd0;
  localparam logic [ERR_W-1:0] ERR_UNTERM   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NONPRINT = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_ESC  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_HEX  = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;

  // characters of interest
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_APOS   = 8'h27;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LO_T   = 8'h74;
  localparam logic [BYTE_W-1:0] CH_LO_N   = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_LO_R   = 8'h72;
  localparam logic [BYTE_W-1:0] CH_LO_X   = 8'h78;
  localparam logic [BYTE_W-1:0] PRINT_LO  = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI  = 8'h7E;

  // one result from a single step
  typedef struct packed {
    logic                valid;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   char_out;
    logic [ERR_W-1:0]    error_code;
  } step_res_t;

  // parser state carried between items
  typedef struct packed {
    phase_t              phase;
    logic [NIB_W-1:0]    high_nibble;
  } parse_st_t;

  // hex digit decode: {is_hex, value}
  function automatic logic [NIB_W:0] hex_decode(input logic [BYTE_W-1:0] b);
    logic [NIB_W:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[NIB_W-1:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      // letters a-f / A-F: low three bits 1..6 map to 10..15
      r = {1'b1, NIB_W'(b[2:0] + 3'd1) + NIB_W'(4'd8) + NIB_W'(4'd0)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qsu_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_step
// Combinational next-state and result logic for one input item.
// ----------------------------------------------------------------------------
module qsu_step
  import qsu_pkg::*;
(
  input  wire logic [BYTE_W-1:0] byte_i,
  input  wire logic              eoi_i,
  input  wire parse_st_t         st_i,
  output parse_st_t              st_o,
  output step_res_t              res_o
);

  logic [NIB_W:0] hex;
  logic           is_hex;

  assign hex    = hex_decode(byte_i);
  assign is_hex = hex[NIB_W] && !eoi_i;

  always_comb begin
    st_o  = st_i;
    res_o = '{valid: 1'b0, kind: KIND_CHAR, char_out: '0, error_code: ERR_NONE};

    case (st_i.phase)
      PH_BODY: begin
        if (eoi_i || byte_i == CH_NL) begin
          st_o.phase = PH_IDLE;
          res_o      = '{1'b1, KIND_ERR, '0, ERR_UNTERM};
        end else if (byte_i == CH_QUOTE) begin
          st_o.phase = PH_IDLE;
          res_o      = '{1'b1, KIND_DONE, '0, ERR_NONE};
        end else if (byte_i == CH_BSLASH) begin
          st_o.phase = PH_ESC;
        end else if (byte_i < PRINT_LO || byte_i > PRINT_HI) begin
          st_o.phase = PH_IDLE;
          res_o      = '{1'b1, KIND_ERR, '0, ERR_NONPRINT};
        end else begin
          res_o = '{1'b1, KIND_CHAR, byte_i, ERR_NONE};
        end
      end

      PH_ESC: begin
        st_o.phase = PH_BODY;
        res_o      = '{1'b1, KIND_CHAR, '0, ERR_NONE};
        if (eoi_i) begin
          st_o.phase = PH_IDLE;
          res_o      = '{1'b1, KIND_ERR, '0, ERR_BAD_ESC};
        end else begin
          case (byte_i)
            CH_LO_T:   res_o.char_out = CH_TAB;
            CH_LO_N:   res_o.char_out = CH_NL;
            CH_LO_R:   res_o.char_out = CH_CR;
            CH_QUOTE:  res_o.char_out = CH_QUOTE;
            CH_APOS:   res_o.char_out = CH_APOS;
            CH_BSLASH: res_o.char_out = CH_BSLASH;
            CH_LO_X: begin
              st_o.phase  = PH_HEX1;
              res_o.valid = 1'b0;
            end
            default: begin
              st_o.phase = PH_IDLE;
              res_o      = '{1'b1, KIND_ERR, '0, ERR_BAD_ESC};
            end
          endcase
        end
      end

      PH_HEX1: begin
        if (is_hex) begin
          st_o.phase       = PH_HEX2;
          st_o.high_nibble = hex[NIB_W-1:0];
        end else begin
          st_o.phase = PH_IDLE;
          res_o      = '{1'b1, KIND_ERR, '0, ERR_BAD_HEX};
        end
      end

      PH_HEX2: begin
        if (is_hex) begin
          st_o.phase = PH_BODY;
          res_o      = '{1'b1, KIND_CHAR, {st_i.high_nibble, hex[NIB_W-1:0]}, ERR_NONE};
        end else begin
          st_o.phase = PH_IDLE;
          res_o      = '{1'b1, KIND_ERR, '0, ERR_BAD_HEX};
        end
      end

      default: begin
        // idle, and any stray phase code
        if (!eoi_i && byte_i == CH_QUOTE) begin
          st_o.phase = PH_BODY;
        end else begin
          st_o.phase = PH_IDLE;
          res_o      = '{1'b1, KIND_ERR, '0, ERR_NO_OPEN};
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/quoted_string_unescaper.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted item passes the input register, then the result register,
// which offers its result on out_valid.
// Throughput: one item per cycle, sustained while out_stall stays low.
// Items that produce no result (opening quote, backslash, first hex digit)
// still pass through the input register but load nothing into the result register.
// Reset (synchronous, rst_n low): both registers empty, parser back to waiting
// for an opening quote, stored hex nibble cleared.
// ----------------------------------------------------------------------------
// quoted_string_unescaper
// Parses a double-quoted string literal one byte per item and emits decoded
// characters, a done mark or a parse error.
// ----------------------------------------------------------------------------
module quoted_string_unescaper
  import qsu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_end_of_input,

  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [KIND_W-1:0] out_kind,
  output      logic [BYTE_W-1:0] out_char_out,
  output      logic [ERR_W-1:0]  out_error_code
);

  // --------------------------------------------------------------------------
  // Input register: holds one accepted item until the step logic consumes it.
  // --------------------------------------------------------------------------
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_eoi_r;

  // Parser state, advanced whenever the held item is consumed
  parse_st_t st_r;
  parse_st_t st_nxt;
  step_res_t res;

  // Result register
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [BYTE_W-1:0] out_char_r;
  logic [ERR_W-1:0]  out_err_r;

  logic out_free;  // result register can take a new result this cycle
  logic consume;   // held item is processed this cycle
  logic in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign consume  = s1_valid_r && out_free;
  // input register refills in the same cycle it drains
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  qsu_step u_step (
    .byte_i (s1_byte_r),
    .eoi_i  (s1_eoi_r),
    .st_i   (st_r),
    .st_o   (st_nxt),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{phase: PH_IDLE, high_nibble: '0};
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
        s1_byte_r  <= in_byte;
        s1_eoi_r   <= in_end_of_input;
      end else if (consume) begin
        s1_valid_r <= 1'b0;
      end

      if (consume) begin
        st_r <= st_nxt;
      end

      // result register: load a fresh result, or drop a taken one
      if (consume && res.valid) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= res.kind;
        out_char_r  <= res.char_out;
        out_err_r   <= res.error_code;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_char_out   = out_char_r;
  assign out_error_code = out_err_r;

endmodule

`default_nettype wire

FILE: rtl/core/qsu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qsu_port_checks
// Port-level checks on the result channel of the unescaper.
// ----------------------------------------------------------------------------
module qsu_port_checks
  import qsu_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [KIND_W-1:0] out_kind,
  input wire logic [BYTE_W-1:0] out_char_out,
  input wire logic [ERR_W-1:0]  out_error_code
);

  // stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_CHAR || out_kind == KIND_DONE || out_kind == KIND_ERR))
    else $error("illegal result kind");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_CHAR |-> out_char_out == '0)
    else $error("character not zero on done or error");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ERR |-> out_error_code == ERR_NONE)
    else $error("error code set on non-error result");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERR |-> out_error_code <= ERR_BAD_HEX)
    else $error("error code out of range");

endmodule

bind quoted_string_unescaper qsu_port_checks u_qsu_port_checks (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_char_out   (out_char_out),
  .out_error_code (out_error_code)
);

`default_nettype wire

FILE: tb/qsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsu_checker
// Watches both channels of the quoted string unescaper. It predicts every
// result from the accepted input items and checks the results in order.
// ----------------------------------------------------------------------------
module qsu_checker
  import qsu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_end_of_input,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [KIND_W-1:0] out_kind,
  input  logic [BYTE_W-1:0] out_char_out,
  input  logic [ERR_W-1:0]  out_error_code,
  output int                items_seen,
  output int                pending,
  output int                fail_count
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] ch;
    logic [ERR_W-1:0]  code;
  } decoded_t;

  decoded_t         decoded_q[$];
  phase_t           parse_phase = PH_IDLE;
  logic [NIB_W-1:0] hi_nibble   = '0;

  // {is_hex, value}
  function automatic logic [NIB_W:0] hex_digit(input logic [BYTE_W-1:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b1, NIB_W'(b - 8'h30)};
    if (b >= 8'h61 && b <= 8'h66) return {1'b1, NIB_W'(b - 8'h57)};
    if (b >= 8'h41 && b <= 8'h46) return {1'b1, NIB_W'(b - 8'h37)};
    return '0;
  endfunction

  task automatic queue_decoded(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] ch,
                               input logic [ERR_W-1:0] code);
    decoded_t d;
    d.kind = kind;
    d.ch   = ch;
    d.code = code;
    decoded_q.push_back(d);
  endtask

  task automatic queue_error(input logic [ERR_W-1:0] code);
    parse_phase = PH_IDLE;
    queue_decoded(KIND_ERR, '0, code);
  endtask

  task automatic queue_char(input logic [BYTE_W-1:0] ch);
    parse_phase = PH_BODY;
    queue_decoded(KIND_CHAR, ch, ERR_NONE);
  endtask

  task automatic decode_item(input logic [BYTE_W-1:0] b, input logic eoi);
    logic [NIB_W:0] hx;
    hx = eoi ? '0 : hex_digit(b);
    case (parse_phase)
      PH_BODY: begin
        // newline wins over the printable check
        if (eoi || b == CH_NL) queue_error(ERR_UNTERM);
        else if (b == CH_QUOTE) begin
          parse_phase = PH_IDLE;
          queue_decoded(KIND_DONE, '0, ERR_NONE);
        end else if (b == CH_BSLASH) parse_phase = PH_ESC;
        else if (b < PRINT_LO || b > PRINT_HI) queue_error(ERR_NONPRINT);
        else queue_char(b);
      end
      PH_ESC: begin
        if (eoi) queue_error(ERR_BAD_ESC);
        else begin
          case (b)
            CH_LO_T:   queue_char(CH_TAB);
            CH_LO_N:   queue_char(CH_NL);
            CH_LO_R:   queue_char(CH_CR);
            CH_QUOTE:  queue_char(CH_QUOTE);
            CH_APOS:   queue_char(CH_APOS);
            CH_BSLASH: queue_char(CH_BSLASH);
            CH_LO_X:   parse_phase = PH_HEX1;
            default:   queue_error(ERR_BAD_ESC);
          endcase
        end
      end
      PH_HEX1: begin
        if (!hx[NIB_W]) queue_error(ERR_BAD_HEX);
        else begin
          hi_nibble   = hx[NIB_W-1:0];
          parse_phase = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (!hx[NIB_W]) queue_error(ERR_BAD_HEX);
        else queue_char({hi_nibble, hx[NIB_W-1:0]});
      end
      default: begin
        if (!eoi && b == CH_QUOTE) parse_phase = PH_BODY;
        else queue_error(ERR_NO_OPEN);
      end
    endcase
  endtask

  always @(posedge clk) begin
    decoded_t exp_d;
    if (!rst_n) begin
      parse_phase = PH_IDLE;
      hi_nibble   = '0;
      decoded_q.delete();
      items_seen  = 0;
      fail_count  = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_item(in_byte, in_end_of_input);
        items_seen++;
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind=%0d char=%02h code=%0d",
                   $time, out_kind, out_char_out, out_error_code);
          fail_count++;
        end else begin
          exp_d = decoded_q.pop_front();
          if (out_kind !== exp_d.kind || out_char_out !== exp_d.ch ||
              out_error_code !== exp_d.code) begin
            $display({"%0t: mismatch, expected kind=%0d char=%02h code=%0d, ",
                      "got kind=%0d char=%02h code=%0d"},
                     $time, exp_d.kind, exp_d.ch, exp_d.code,
                     out_kind, out_char_out, out_error_code);
            fail_count++;
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

FILE: tb/quoted_string_unescaper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_unescaper_tb
// Drives byte items into the unescaper: a short directed list, then random
// string literals, mostly well formed, some broken, some noise. A checker
// beside the block predicts and compares every result; this module makes
// the traffic, the idle/stall patterns and the verdict.
// ----------------------------------------------------------------------------
module quoted_string_unescaper_tb;
  import qsu_pkg::*;

  localparam int TOTAL_ITEMS    = 1950;
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int HOLD_AT_ITEM   = 60;    // where the long receiver hold starts
  localparam int HOLD_CYCLES    = 64;
  localparam int DRAIN_CYCLES   = 8;     // a few times the two-register depth

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              eoi;
  } stim_t;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte         = '0;
  logic              in_end_of_input = 1'b0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_char_out;
  logic [ERR_W-1:0]  out_error_code;

  stim_t stim_q[$];
  int    stim_total     = TOTAL_ITEMS;
  int    next_idx       = 0;
  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;
  int    hold_left      = 0;
  bit    hold_done      = 1'b0;
  int    quiet_cycles   = 0;
  int    items_seen;
  int    pending;
  int    fail_count;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  quoted_string_unescaper u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_char_out    (out_char_out),
    .out_error_code  (out_error_code)
  );

  qsu_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_char_out    (out_char_out),
    .out_error_code  (out_error_code),
    .items_seen      (items_seen),
    .pending         (pending),
    .fail_count      (fail_count)
  );

  // --------------------------------------------------------------------------
  // Stimulus building blocks
  // --------------------------------------------------------------------------
  task automatic push_item(input logic [BYTE_W-1:0] b, input logic eoi);
    stim_t s;
    s.b   = b;
    s.eoi = eoi;
    stim_q.push_back(s);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endtask

  // end-of-input mark; the byte rides along with random content
  task automatic push_eoi();
    push_item(BYTE_W'($urandom), 1'b1);
  endtask

  function automatic logic [BYTE_W-1:0] rand_hex_char();
    string hex_chars;
    hex_chars = "0123456789abcdefABCDEF";
    return hex_chars[$urandom_range(21)];
  endfunction

  // printable, but neither the closing quote nor the escape lead-in
  function automatic logic [BYTE_W-1:0] rand_plain_char();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(PRINT_LO, PRINT_HI));
    while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  // one body element: a plain char or any of the escapes
  task automatic push_body_elem();
    if ($urandom_range(9) < 6) begin
      push_item(rand_plain_char(), 1'b0);
    end else begin
      push_item(CH_BSLASH, 1'b0);
      case ($urandom_range(6))
        0: push_item(CH_LO_T, 1'b0);
        1: push_item(CH_LO_N, 1'b0);
        2: push_item(CH_LO_R, 1'b0);
        3: push_item(CH_QUOTE, 1'b0);
        4: push_item(CH_APOS, 1'b0);
        5: push_item(CH_BSLASH, 1'b0);
        default: begin
          push_item(CH_LO_X, 1'b0);
          push_item(rand_hex_char(), 1'b0);
          push_item(rand_hex_char(), 1'b0);
        end
      endcase
    end
  endtask

  // A literal with a random body. Most are closed properly; the rest
  // break off with one of the parse errors at the end of the body.
  task automatic push_literal();
    logic [BYTE_W-1:0] b;
    int                n;
    n = $urandom_range(12);
    push_item(CH_QUOTE, 1'b0);
    for (int i = 0; i < n; i++) push_body_elem();
    if ($urandom_range(99) < 70) begin
      push_item(CH_QUOTE, 1'b0);
    end else begin
      case ($urandom_range(5))
        0: push_item(CH_NL, 1'b0);
        1: push_eoi();
        2: begin
          // control byte (newline aside) or anything above '~'
          do b = BYTE_W'($urandom);
          while (!((b < PRINT_LO && b != CH_NL) || b > PRINT_HI));
          push_item(b, 1'b0);
        end
        3: begin
          push_item(CH_BSLASH, 1'b0);
          if ($urandom_range(3) == 0) push_eoi();
          else begin
            do b = BYTE_W'($urandom);
            while (b == CH_LO_T || b == CH_LO_N || b == CH_LO_R || b == CH_QUOTE ||
                   b == CH_APOS || b == CH_BSLASH || b == CH_LO_X);
            push_item(b, 1'b0);
          end
        end
        default: begin
          // bad digit in either hex position
          push_item(CH_BSLASH, 1'b0);
          push_item(CH_LO_X, 1'b0);
          if ($urandom_range(1) == 1) push_item(rand_hex_char(), 1'b0);
          if ($urandom_range(3) == 0) push_eoi();
          else begin
            do b = BYTE_W'($urandom);
            while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                   (b >= 8'h61 && b <= 8'h66));
            push_item(b, 1'b0);
          end
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Traffic shaping: the run is split into four stretches by item index.
  //   0: no idling at all (also hosts the long receiver hold)
  //   1: sender idle about half the time
  //   2: receiver stalling about half the time
  //   3: both, at about a fifth
  // --------------------------------------------------------------------------
  always @* begin
    case ((next_idx * 4) / stim_total)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
      default: begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
  end

  // Sender: a new item is loaded only once the current one is taken, so a
  // stalled payload holds still.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (next_idx < stim_q.size() && $urandom_range(99) >= send_idle_pct) begin
        in_valid        <= 1'b1;
        in_byte         <= stim_q[next_idx].b;
        in_end_of_input <= stim_q[next_idx].eoi;
        next_idx        <= next_idx + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, plus one long hold while the sender keeps
  // offering items, so both pipeline registers fill and in_stall rises.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && next_idx >= HOLD_AT_ITEM) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any handshake on either channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Directed part: idle errors, printable extremes, escapes and hex in
    // both cases, then a literal for each error kind.
    push_item(8'hFF, 1'b1);       // end of input while idle
    push_text("a");               // stray byte while idle
    push_text("\" ~\\t\\xAf\"");  // ' ', '~', tab escape, hex 0xAF, close
    push_text("\"\\q");           // unknown escape
    push_item(CH_QUOTE, 1'b0);
    push_item(8'h7F, 1'b0);       // just above printable
    push_text("\"\n");            // newline ends the body early
    push_text("\"\\xg");          // non-hex digit
    push_item(CH_QUOTE, 1'b0);
    push_item(8'h00, 1'b1);       // end of input inside the body

    // Random part: mostly literals, a little raw noise between them.
    while (stim_q.size() < TOTAL_ITEMS) begin
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(7) == 0) push_eoi();
          else push_item(BYTE_W'($urandom), 1'b0);
        end
      end else begin
        push_literal();
      end
    end
    stim_total = stim_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Sample on the falling edge so checker updates have settled.
    do @(negedge clk);
    while (!(items_seen == stim_total && pending == 0));
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
